// ===== hw/rtl/udp_receive_checker_top_assert.svh =====
// Assertion macros shared by the UDP receive checker modules.
// No dependencies; included by each module that carries assertions.
`ifndef UDP_RECEIVE_CHECKER_TOP_ASSERT_SVH
`define UDP_RECEIVE_CHECKER_TOP_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define UDPC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent that must hold in the same cycle as its antecedent.
`define UDPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/udpc_pkg.sv =====
// Shared types, constants and codes of the UDP receive checker.
// No dependencies; imported by every module of the block.
package udpc_pkg;

	// Number of port slots the register map provides.
	localparam int HARD_SLOTS = 4;
	localparam int PORT_SLOTS_DEF = 4;
	localparam int QUEUE_DEPTH_DEF = 4;

	// IP protocol number of UDP, a term of the pseudo-header.
	localparam logic [15:0] UDP_PROTO = 16'd17;

	// Shortest legal datagram: the eight header bytes.
	localparam logic [15:0] MIN_LEN = 16'd8;

	// Verdict codes.
	localparam logic [2:0] VERDICT_DELIVER   = 3'd0;
	localparam logic [2:0] VERDICT_SHORT     = 3'd1;
	localparam logic [2:0] VERDICT_LEN_BAD   = 3'd2;
	localparam logic [2:0] VERDICT_CKSUM_BAD = 3'd3;
	localparam logic [2:0] VERDICT_NO_PORT   = 3'd4;

	// Configuration register indexes.
	localparam logic [2:0] REG_LOCAL_IP  = 3'd0;
	localparam logic [2:0] REG_PORT_A    = 3'd1;
	localparam logic [2:0] REG_PORT_MASK = 3'd5;

	// One finished datagram, handed from the front end to the back end.
	typedef struct packed {
		logic [15:0] sum;      // folded sum over the datagram words
		logic [7:0]  hold;     // pending high byte when the count is odd
		logic [15:0] count;    // saturated byte count
		logic [15:0] src;
		logic [15:0] dst;
		logic [15:0] len;
		logic [15:0] cks;
		logic [31:0] peer;
	} rec_t;

	// One verdict as shown on the output.
	typedef struct packed {
		logic [15:0] cks;
		logic [15:0] len;
		logic [15:0] dst;
		logic [15:0] src;
		logic [1:0]  slot;
		logic [2:0]  verdict;
	} res_t;

endpackage

// ===== hw/rtl/udp_receive_checker_top.sv =====
// Top level of the UDP receive checker: configuration registers, stream
// ports and the front end, record queue and back end. Depends on udpc_pkg.
//
// The checker takes one datagram byte per cycle on s_tdata, with the peer
// address on every byte and s_tlast on the final one, and sums the datagram
// and its IPv4 pseudo-header in one's complement. For each datagram it shows
// one verdict on m_tdata through the record queue, stage-1 register and output
// register. Bytes stream at one per cycle while s_tready is high; only a full
// record queue (QUEUE_DEPTH records waiting behind the two filled stages of a
// stalled back end) drops s_tready. Per-byte throughput is set by the single
// 16-bit end-around add of the front end. Configuration writes
// are taken in any cycle and should happen only while no datagram is in flight.
module udp_receive_checker_top #(
	parameter int PORT_SLOTS  = udpc_pkg::PORT_SLOTS_DEF,
	parameter int QUEUE_DEPTH = udpc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Datagram byte stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,    // [7:0] data_byte, [39:8] peer_ip
	input  logic        s_tlast,    // last_byte
	// Verdict stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] verdict, [4:3] port_slot, [20:5] source_port, [36:21] dest_port,
	// [52:37] received_length, [68:53] computed_checksum, [71:69] zero
	output logic [71:0] m_tdata,
	// Configuration writes.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import udpc_pkg::*;

	// Slots beyond the register map are never matched.
	localparam int NUM_SLOTS = (PORT_SLOTS < HARD_SLOTS) ? PORT_SLOTS : HARD_SLOTS;

	logic [31:0]          local_ip_q;
	logic [15:0]          port_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] mask_q;
	logic                 cfg_write;

	logic q_full, q_push, q_pop, q_valid;
	rec_t q_wr, q_rd;
	res_t res;

	// Configuration registers; writes to unknown indexes are dropped.
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q <= '0;
			mask_q     <= '0;
		end else if (cfg_write) begin
			if (cfg_index == REG_LOCAL_IP) begin
				local_ip_q <= cfg_data;
			end
			if (cfg_index == REG_PORT_MASK) begin
				mask_q <= cfg_data[NUM_SLOTS-1:0];
			end
		end
	end

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_port
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				port_q[i] <= '0;
			end else if (cfg_write && (cfg_index == REG_PORT_A + 3'(i))) begin
				port_q[i] <= cfg_data[15:0];
			end
		end
	end

	udpc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.data_byte(s_tdata[7:0]),
		.last_byte(s_tlast),
		.peer_ip  (s_tdata[39:8]),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wr)
	);

	udpc_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_data  (q_wr),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_valid),
		.rd_data  (q_rd)
	);

	udpc_back #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_rd),
		.q_pop    (q_pop),
		.local_ip (local_ip_q),
		.port_num (port_q),
		.port_mask(mask_q),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (res)
	);

	// Pack the verdict fields, first field in the lowest bits.
	assign m_tdata = {3'b000, res.cks, res.len, res.dst, res.src, res.slot, res.verdict};

endmodule

// ===== hw/rtl/udpc_fifo.sv =====
// Short queue of finished datagram records between front and back end.
// Depends on udpc_pkg and udp_receive_checker_top_assert.svh.
`include "udp_receive_checker_top_assert.svh"

module udpc_fifo #(
	parameter int DEPTH = udpc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  udpc_pkg::rec_t wr_data,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output udpc_pkg::rec_t rd_data
);
	import udpc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rec_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];

	// Storage writes; the records need no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`UDPC_ASSERT(a_count_range, clk, arst_n, count_q <= CW'(DEPTH), "queue level beyond depth")
	`UDPC_ASSERT_IMP(a_no_overflow, clk, arst_n, push, !full, "push into a full queue")
	`UDPC_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, not_empty, "pop from an empty queue")

endmodule

// ===== hw/rtl/udpc_front.sv =====
// Front end: takes datagram bytes, keeps the running sum and header fields,
// and queues one record per datagram. Depends on udpc_pkg.
module udpc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     data_byte,
	input  logic           last_byte,
	input  logic [31:0]    peer_ip,
	input  logic           q_full,
	output logic           q_push,
	output udpc_pkg::rec_t q_data
);
	import udpc_pkg::*;

	// Byte offsets of the header fields.
	localparam logic [2:0] OFS_SRC_HI = 3'd0;
	localparam logic [2:0] OFS_SRC_LO = 3'd1;
	localparam logic [2:0] OFS_DST_HI = 3'd2;
	localparam logic [2:0] OFS_DST_LO = 3'd3;
	localparam logic [2:0] OFS_LEN_HI = 3'd4;
	localparam logic [2:0] OFS_LEN_LO = 3'd5;
	localparam logic [2:0] OFS_CKS_HI = 3'd6;
	localparam logic [2:0] OFS_CKS_LO = 3'd7;

	logic [15:0] count_q, sum_q, src_q, dst_q, len_q, cks_q;
	logic [7:0]  hold_q;

	logic [15:0] count_d, sum_d, src_d, dst_d, len_d, cks_d;
	logic [7:0]  hold_d;
	logic [7:0]  word_lo;
	logic [16:0] sum_wide;
	logic        accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Per-byte update; once the count is saturated nothing changes.
	always_comb begin
		count_d  = count_q;
		sum_d    = sum_q;
		hold_d   = hold_q;
		src_d    = src_q;
		dst_d    = dst_q;
		len_d    = len_q;
		cks_d    = cks_q;
		word_lo  = data_byte;
		sum_wide = {1'b0, sum_q} + {1'b0, hold_q, data_byte};
		if (count_q != 16'hFFFF) begin
			if (count_q[15:3] == '0) begin
				unique case (count_q[2:0])
					OFS_SRC_HI: src_d = {data_byte, 8'h00};
					OFS_SRC_LO: src_d = {src_q[15:8], data_byte};
					OFS_DST_HI: dst_d = {data_byte, 8'h00};
					OFS_DST_LO: dst_d = {dst_q[15:8], data_byte};
					OFS_LEN_HI: len_d = {data_byte, 8'h00};
					OFS_LEN_LO: len_d = {len_q[15:8], data_byte};
					OFS_CKS_HI: cks_d = {data_byte, 8'h00};
					OFS_CKS_LO: cks_d = {cks_q[15:8], data_byte};
				endcase
				// The checksum field itself counts as zero in the sum.
				if (count_q[2:0] == OFS_CKS_HI || count_q[2:0] == OFS_CKS_LO) begin
					word_lo  = 8'h00;
					sum_wide = {1'b0, sum_q} + {1'b0, hold_q, 8'h00};
				end
			end
			if (!count_q[0]) begin
				hold_d = word_lo;
			end else begin
				// End-around carry; one fold suffices for a 16-bit sum.
				sum_d = sum_wide[15:0] + {15'b0, sum_wide[16]};
			end
			count_d = count_q + 16'd1;
		end
	end

	// Record of the finished datagram, pushed on its last byte.
	assign q_push = accept && last_byte;
	assign q_data = '{sum: sum_d, hold: hold_d, count: count_d, src: src_d, dst: dst_d,
		len: len_d, cks: cks_d, peer: peer_ip};

	// Per-datagram state, cleared after every last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			hold_q  <= '0;
			src_q   <= '0;
			dst_q   <= '0;
			len_q   <= '0;
			cks_q   <= '0;
		end else if (accept) begin
			if (last_byte) begin
				count_q <= '0;
				sum_q   <= '0;
				hold_q  <= '0;
				src_q   <= '0;
				dst_q   <= '0;
				len_q   <= '0;
				cks_q   <= '0;
			end else begin
				count_q <= count_d;
				sum_q   <= sum_d;
				hold_q  <= hold_d;
				src_q   <= src_d;
				dst_q   <= dst_d;
				len_q   <= len_d;
				cks_q   <= cks_d;
			end
		end
	end

endmodule

// ===== hw/rtl/udpc_back.sv =====
// Back end: adds the pseudo-header, checks the datagram and holds the verdict
// in the output register. Depends on udpc_pkg and the assertion header.
`include "udp_receive_checker_top_assert.svh"

module udpc_back #(
	parameter int NUM_SLOTS = udpc_pkg::HARD_SLOTS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  udpc_pkg::rec_t       q_data,
	output logic                 q_pop,
	input  logic [31:0]          local_ip,
	input  logic [15:0]          port_num [NUM_SLOTS],
	input  logic [NUM_SLOTS-1:0] port_mask,
	output logic                 out_valid,
	input  logic                 out_ready,
	output udpc_pkg::res_t       out_data
);
	import udpc_pkg::*;

	logic        valid_s1;
	logic [18:0] sum_s1;
	logic        short_s1, len_bad_s1, hit_s1;
	logic [1:0]  slot_s1;
	logic [15:0] cks_s1, src_s1, dst_s1, count_s1;

	logic        out_valid_q;
	res_t        out_q;

	logic        adv_out, adv_s1;
	logic [15:0] pad_word;
	logic [18:0] sum_total;
	logic [NUM_SLOTS-1:0] hit;
	logic [1:0]  slot_first;
	logic [16:0] fold1;
	logic [15:0] fold2, computed;
	logic [2:0]  verdict;

	assign adv_out = !out_valid_q || out_ready;
	assign adv_s1  = !valid_s1 || adv_out;
	assign q_pop   = q_valid && adv_s1;

	// Stage 1: one wide add of every word, and the port lookup.
	assign pad_word  = q_data.count[0] ? {q_data.hold, 8'h00} : 16'h0000;
	assign sum_total = 19'(q_data.sum) + 19'(pad_word)
		+ 19'(q_data.peer[31:16]) + 19'(q_data.peer[15:0])
		+ 19'(local_ip[31:16]) + 19'(local_ip[15:0])
		+ 19'(UDP_PROTO) + 19'(q_data.count);

	// Lowest enabled slot that holds the destination port wins.
	always_comb begin
		slot_first = 2'd0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			hit[i] = port_mask[i] && (port_num[i] == q_data.dst);
			if (hit[i]) begin
				slot_first = 2'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			sum_s1     <= sum_total;
			short_s1   <= q_data.count < MIN_LEN;
			len_bad_s1 <= q_data.count < q_data.len;
			hit_s1     <= |hit;
			slot_s1    <= slot_first;
			cks_s1     <= q_data.cks;
			src_s1     <= q_data.src;
			dst_s1     <= q_data.dst;
			count_s1   <= q_data.count;
		end
	end

	// Stage 2: fold the sum, then pick the first verdict that applies.
	assign fold1    = 17'(sum_s1[15:0]) + 17'(sum_s1[18:16]);
	assign fold2    = fold1[15:0] + {15'b0, fold1[16]};
	assign computed = ~fold2;

	always_comb begin
		priority if (short_s1) begin
			verdict = VERDICT_SHORT;
		end else if (len_bad_s1) begin
			verdict = VERDICT_LEN_BAD;
		end else if (computed != cks_s1) begin
			verdict = VERDICT_CKSUM_BAD;
		end else if (hit_s1) begin
			verdict = VERDICT_DELIVER;
		end else begin
			verdict = VERDICT_NO_PORT;
		end
	end

	// Output register; loads whenever it is empty or being drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			out_q.verdict <= verdict;
			out_q.slot    <= (verdict == VERDICT_DELIVER) ? slot_s1 : 2'd0;
			out_q.src     <= src_s1;
			out_q.dst     <= dst_s1;
			out_q.len     <= count_s1;
			out_q.cks     <= computed;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`UDPC_ASSERT_IMP(a_slot_only_on_deliver, clk, arst_n,
		out_valid_q && (out_q.verdict != VERDICT_DELIVER), out_q.slot == 2'd0,
		"port slot set on a rejected datagram")

endmodule
